// ===== rtl/skf_pkg.sv =====
// Package with the widths, constants, sequencer states and control struct of the Kalman filter.
`timescale 1ns / 1ps

package skf_pkg;

  // Field widths.
  localparam int unsigned DataW  = 32;
  localparam int unsigned GainW  = 17;
  localparam int unsigned FracW  = 16;
  localparam int unsigned CfgIdxW = 1;

  // Quotient bits of the gain division, one per divider step.
  localparam int unsigned DivSteps = GainW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // Gain of exactly one in Q1.16.
  localparam logic [GainW-1:0] OneQ16 = GainW'(1) << FracW;

  // Saturation ceiling of the covariance.
  localparam logic [DataW-1:0] CovMax = '1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegProcessNoise     = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMeasurementNoise = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [DataW-1:0] ProcessNoiseRst     = 32'd655;
  localparam logic [DataW-1:0] MeasurementNoiseRst = 32'd65536;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DEN,
    ST_DIV,
    ST_MEST,
    ST_MCOV,
    ST_FIN,
    ST_OUT
  } state_e;

  // Step strobes from the sequencer to the datapath.
  typedef struct packed {
    logic in_rdy;
    logic pred;
    logic den;
    logic div_step;
    logic mul_est;
    logic mul_cov;
    logic fin;
    logic out_load;
  } ctrl_t;

endpackage

// ===== rtl/skf_if.sv =====
// Stream interfaces for measurements in and filter results out.
`timescale 1ns / 1ps

interface skf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [skf_pkg::DataW-1:0]  measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [skf_pkg::DataW-1:0]  estimate;
  logic        [skf_pkg::GainW-1:0]  gain;

  modport source (output valid, output estimate, output gain, input ready);
  modport sink   (input valid, input estimate, input gain, output ready);
endinterface

// ===== rtl/scalar_kalman_filter.sv =====
// Top level of the one-dimensional Kalman filter.
//
//   channel    dir  signals                         moves
//   meas_i     in   valid ready measurement         one sensor sample per transfer
//   result_o   out  valid ready estimate gain       one filter result per transfer
//   cfg_*_i    in   we idx data                     process and measurement noise writes
//
// After its transfer, a sample passes through the prediction, the divisor, the 17 steps of
// the radix-2 gain divider, two multiplies on the shared multiplier, the covariance and the
// load of the result register. The sequencer then goes back to idle to take the next
// sample once the output register is free.
// Input ready is high only while the sequencer is idle. A finished result waits in the
// output register while the next sample is taken; a sample that finishes before that
// result is taken holds in the last step. Reset and any configuration write clear the
// estimate and the covariance.
`timescale 1ns / 1ps

module scalar_kalman_filter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  skf_in_if.sink                             meas_i,
  skf_out_if.source                          result_o,
  input  logic                               cfg_we_i,
  input  logic [skf_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [skf_pkg::DataW-1:0]          cfg_data_i
);

  skf_pkg::ctrl_t ctrl;
  logic           out_free;
  logic           in_fire;

  assign meas_i.ready = ctrl.in_rdy;
  assign in_fire      = meas_i.valid && ctrl.in_rdy;

  // Sequencer.
  skf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (meas_i.valid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // Arithmetic and state.
  skf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .in_fire_i      (in_fire),
    .meas_i         (meas_i.measurement),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .out_free_o     (out_free),
    .out_estimate_o (result_o.estimate),
    .out_gain_o     (result_o.gain)
  );

  // A sample transfer starts a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !meas_i.ready)
    else $error("input still ready right after a sample transfer");

  // The gain never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.gain <= skf_pkg::OneQ16)
    else $error("gain above one");

  // A new result appears only through a load by the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(ctrl.out_load))
    else $error("result valid without a load");

  // The sequencer strobes at most one step per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ctrl))
    else $error("more than one sequencer step active");

endmodule

// ===== rtl/skf_ctrl.sv =====
// Sequencer that steps the shared divider and multiplier through one filter update.
`timescale 1ns / 1ps

module skf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_free_i,
  output skf_pkg::ctrl_t        ctrl_o
);

  skf_pkg::state_e              state_q, state_d;
  logic [skf_pkg::CntW-1:0]     cnt_q, cnt_d;

  localparam logic [skf_pkg::CntW-1:0] LastStep = skf_pkg::CntW'(skf_pkg::DivSteps - 1);

  // State and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skf_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      skf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = skf_pkg::ST_PRED;
      end
      skf_pkg::ST_PRED: state_d = skf_pkg::ST_DEN;
      skf_pkg::ST_DEN: begin
        state_d = skf_pkg::ST_DIV;
        cnt_d   = '0;
      end
      skf_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastStep) state_d = skf_pkg::ST_MEST;
      end
      skf_pkg::ST_MEST: state_d = skf_pkg::ST_MCOV;
      skf_pkg::ST_MCOV: state_d = skf_pkg::ST_FIN;
      skf_pkg::ST_FIN:  state_d = skf_pkg::ST_OUT;
      skf_pkg::ST_OUT: begin
        if (out_free_i) state_d = skf_pkg::ST_IDLE;
      end
      default: state_d = skf_pkg::ST_IDLE;
    endcase
  end

  // Step strobes.
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      skf_pkg::ST_IDLE: ctrl_o.in_rdy   = 1'b1;
      skf_pkg::ST_PRED: ctrl_o.pred     = 1'b1;
      skf_pkg::ST_DEN:  ctrl_o.den      = 1'b1;
      skf_pkg::ST_DIV:  ctrl_o.div_step = 1'b1;
      skf_pkg::ST_MEST: ctrl_o.mul_est  = 1'b1;
      skf_pkg::ST_MCOV: ctrl_o.mul_cov  = 1'b1;
      skf_pkg::ST_FIN:  ctrl_o.fin      = 1'b1;
      skf_pkg::ST_OUT:  ctrl_o.out_load = out_free_i;
      default:          ctrl_o = '0;
    endcase
  end

endmodule

// ===== rtl/skf_dp.sv =====
// Datapath with the filter state, one compare-subtract divider step and one shared multiplier.
`timescale 1ns / 1ps

module skf_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  skf_pkg::ctrl_t                     ctrl_i,
  input  logic                               in_fire_i,
  input  logic signed [skf_pkg::DataW-1:0]   meas_i,
  input  logic                               cfg_we_i,
  input  logic [skf_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [skf_pkg::DataW-1:0]          cfg_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_free_o,
  output logic signed [skf_pkg::DataW-1:0]   out_estimate_o,
  output logic [skf_pkg::GainW-1:0]          out_gain_o
);

  localparam int unsigned DW = skf_pkg::DataW;
  localparam int unsigned GW = skf_pkg::GainW;
  localparam int unsigned FW = skf_pkg::FracW;
  localparam int unsigned PW = GW + 1 + DW + 1;

  // Configuration and filter state.
  logic [DW-1:0]          q_noise_q, r_noise_q;
  logic signed [DW-1:0]   est_q;
  logic [DW-1:0]          cov_q;

  // Working registers of one update.
  logic signed [DW-1:0]   meas_q;
  logic [DW-1:0]          pp_q;
  logic signed [DW:0]     diff_q;
  logic [DW:0]            den_q;
  logic                   den_zero_q;
  logic [DW+1:0]          rem_q;
  logic [GW-1:0]          quot_q;
  logic signed [PW-1:0]   prod_q;

  // Result register.
  logic                   out_valid_q;
  logic signed [DW-1:0]   out_est_q;
  logic [GW-1:0]          out_gain_q;

  // Combinational terms.
  logic [DW:0]            pp_sum;
  logic [DW-1:0]          pp_sat;
  logic signed [DW+2:0]   trial;
  logic                   q_bit;
  logic [DW+1:0]          rem_next;
  logic [GW-1:0]          gain_w;
  logic signed [GW:0]     mul_a;
  logic signed [DW:0]     mul_b;
  logic signed [PW-1:0]   prod_d;
  logic signed [PW-1:0]   prod_sh;
  logic                   cfg_hit;

  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i == skf_pkg::RegProcessNoise ||
                    cfg_idx_i == skf_pkg::RegMeasurementNoise);

  // Predicted covariance, saturated at the top of the range.
  assign pp_sum = {1'b0, cov_q} + {1'b0, q_noise_q};
  assign pp_sat = pp_sum[DW] ? skf_pkg::CovMax : pp_sum[DW-1:0];

  // One restoring division step: compare and subtract the divisor.
  assign trial    = $signed({1'b0, rem_q}) - $signed({2'b00, den_q});
  assign q_bit    = !trial[DW+2];
  assign rem_next = q_bit ? trial[DW+1:0] : rem_q;

  // Gain is zero when the divisor is zero.
  assign gain_w = den_zero_q ? '0 : quot_q;

  // Shared multiplier: gain times innovation, then (one - gain) times covariance.
  always_comb begin
    if (ctrl_i.mul_est) begin
      mul_a = $signed({1'b0, gain_w});
      mul_b = diff_q;
    end else begin
      mul_a = $signed({1'b0, GW'(skf_pkg::OneQ16 - gain_w)});
      mul_b = $signed({1'b0, pp_q});
    end
  end

  assign prod_d  = PW'(mul_a) * PW'(mul_b);
  assign prod_sh = prod_q >>> FW;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= skf_pkg::ProcessNoiseRst;
      r_noise_q <= skf_pkg::MeasurementNoiseRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == skf_pkg::RegProcessNoise) q_noise_q <= cfg_data_i;
      if (cfg_idx_i == skf_pkg::RegMeasurementNoise) r_noise_q <= cfg_data_i;
    end
  end

  // Estimate and covariance; a configuration write restarts the filter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      cov_q <= '0;
    end else if (cfg_hit) begin
      est_q <= '0;
      cov_q <= '0;
    end else begin
      if (ctrl_i.mul_cov) est_q <= est_q + prod_sh[DW-1:0];
      if (ctrl_i.fin)     cov_q <= prod_q[DW+FW-1:FW];
    end
  end

  // Working registers, stepped by the sequencer.
  always_ff @(posedge clk_i) begin
    if (in_fire_i) meas_q <= meas_i;
    if (ctrl_i.pred) begin
      pp_q   <= pp_sat;
      diff_q <= $signed({meas_q[DW-1], meas_q}) - $signed({est_q[DW-1], est_q});
    end
    if (ctrl_i.den) begin
      den_q      <= {1'b0, pp_q} + {1'b0, r_noise_q};
      den_zero_q <= (pp_q == '0) && (r_noise_q == '0);
      rem_q      <= {2'b00, pp_q};
    end
    if (ctrl_i.div_step) begin
      rem_q  <= {rem_next[DW:0], 1'b0};
      quot_q <= {quot_q[GW-2:0], q_bit};
    end
    if (ctrl_i.mul_est || ctrl_i.mul_cov) prod_q <= prod_d;
  end

  // Result register, free again once its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_est_q  <= est_q;
      out_gain_q <= gain_w;
    end
  end

  assign out_free_o     = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_estimate_o = out_est_q;
  assign out_gain_o     = out_gain_q;

endmodule
